@@ rtl/lifo_stack_with_search_defines.svh @@
// Assertion macros used by the checker file of the stack block.
`ifndef LIFO_STACK_WITH_SEARCH_DEFINES_SVH
`define LIFO_STACK_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LSWS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stack check failed");

// Next-cycle implication, disabled while reset is held.
`define LSWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stack check failed");

`endif

@@ rtl/lsws_pkg.sv @@
// Shared constants, codes and controller/datapath command types of the stack block.
`timescale 1ns / 1ps
`default_nettype none

package lsws_pkg;

    localparam int OPCODE_W = 2;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;      // take the request beat
        logic take_top;  // latch the read top entry as result
        logic scan;      // walk the search one step
        logic emit;      // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic go_read;   // accepted pop or peek needs the top entry
        logic go_scan;   // accepted search has entries to walk
        logic scan_end;  // search hit or last entry compared
        logic out_free;  // output register can load this cycle
    } t_status;

endpackage

`default_nettype wire

@@ rtl/lsws_if.sv @@
// Request and response channel interfaces of the stack block.
`timescale 1ns / 1ps
`default_nettype none

interface lsws_req_if import lsws_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic        [OPCODE_W-1:0] opcode;
    logic signed [DATA_W-1:0]   operand_value;

    modport source (output valid, output opcode, output operand_value, input ready);
    modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

interface lsws_rsp_if import lsws_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   result_value;
    logic                       found;
    logic        [POS_W-1:0]    position;
    logic                       is_empty;
    logic        [STATUS_W-1:0] status;

    modport source (output valid, output result_value, output found, output position,
                    output is_empty, output status, input ready);
    modport sink   (input valid, input result_value, input found, input position,
                    input is_empty, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/lsws_ctrl.sv @@
// Controller state machine of the stack block.
`timescale 1ns / 1ps
`default_nettype none

module lsws_ctrl import lsws_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_req_valid,
    output logic         o_req_ready,
    input  wire t_status i_st,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_st.go_read) begin
                        n_state = S_READ;
                    end else if (i_st.go_scan) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                o_cmd.take_top = 1'b1;
                n_state        = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_st.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/lsws_datapath.sv @@
// Datapath of the stack block: entry memory, count, search walk and output register.
`timescale 1ns / 1ps
`default_nettype none

module lsws_datapath import lsws_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_st,
    input  wire        [OPCODE_W-1:0] i_opcode,
    input  wire signed [DATA_W-1:0]   i_operand_value,
    input  wire                       i_rsp_ready,
    output logic                      o_rsp_valid,
    output logic signed [DATA_W-1:0]  o_result_value,
    output logic                      o_found,
    output logic       [POS_W-1:0]    o_position,
    output logic                      o_is_empty,
    output logic       [STATUS_W-1:0] o_status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0]   r_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   r_rd_data;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_scan_addr;
    logic [AW-1:0]       r_cmp_idx;
    logic                r_cmp_valid;
    logic [DATA_W-1:0]   r_val;
    logic [DATA_W-1:0]   r_res_value;
    logic                r_found;
    logic [POS_W-1:0]    r_pos;
    logic [STATUS_W-1:0] r_status;
    logic                r_out_valid;

    logic          w_empty;
    logic          w_full;
    logic          w_push;
    logic          w_pop;
    logic          w_peek;
    logic          w_search;
    logic [CW-1:0] w_count_dec;
    logic [CW-1:0] w_cmp_next;
    logic          w_hit;
    logic          w_issue;
    logic          w_wr_en;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;

    always_comb begin
        w_empty     = (r_count == '0);
        w_full      = (r_count == CW'(STACK_DEPTH));
        w_push      = (i_opcode == OP_PUSH);
        w_pop       = (i_opcode == OP_POP);
        w_peek      = (i_opcode == OP_PEEK);
        w_search    = (i_opcode == OP_SEARCH);
        w_count_dec = r_count - CW'(1);
        w_cmp_next  = CW'(r_cmp_idx) + CW'(1);
        w_hit       = r_cmp_valid && (r_rd_data == r_val);
        w_issue     = i_cmd.scan && !w_hit && (r_scan_addr < r_count);
        w_wr_en     = i_cmd.load && w_push && !w_full;
        w_rd_en     = i_cmd.load || w_issue;
        if (i_cmd.load) begin
            w_rd_addr = w_search ? '0 : w_count_dec[AW-1:0];
        end else begin
            w_rd_addr = r_scan_addr[AW-1:0];
        end

        o_st.go_read  = (w_pop || w_peek) && !w_empty;
        o_st.go_scan  = w_search && !w_empty;
        o_st.scan_end = w_hit || (r_cmp_valid && (w_cmp_next == r_count));
        o_st.out_free = !r_out_valid || i_rsp_ready;
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[AW-1:0]] <= i_operand_value;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (w_push && !w_full) begin
                    r_count <= r_count + CW'(1);
                end else if (w_pop && !w_empty) begin
                    r_count <= w_count_dec;
                end
                r_cmp_valid <= !w_empty;
            end else if (i_cmd.scan) begin
                r_cmp_valid <= w_issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val       <= i_operand_value;
            r_res_value <= '0;
            r_found     <= 1'b0;
            r_pos       <= '0;
            r_scan_addr <= CW'(1);
            r_cmp_idx   <= '0;
            if (w_push && w_full) begin
                r_status <= ST_OVERFLOW;
            end else if ((w_pop || w_peek) && w_empty) begin
                r_status <= ST_UNDERFLOW;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (i_cmd.take_top) begin
            r_res_value <= r_rd_data;
        end
        if (i_cmd.scan) begin
            if (w_hit) begin
                r_found <= 1'b1;
                r_pos   <= POS_W'(w_cmp_next);
            end
            if (w_issue) begin
                r_cmp_idx   <= r_scan_addr[AW-1:0];
                r_scan_addr <= r_scan_addr + CW'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_result_value <= r_res_value;
            o_found        <= r_found;
            o_position     <= r_pos;
            o_is_empty     <= w_empty;
            o_status       <= r_status;
        end
    end

    assign o_rsp_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/lifo_stack_with_search.sv @@
// Top level of the bounded LIFO stack with bottom-up search.
`timescale 1ns / 1ps
`default_nettype none

// Bounded LIFO stack of STACK_DEPTH signed 32-bit words. Each request beat
// carries an opcode (push, pop, peek, search) and a value; each gives exactly
// one response beat with the popped or peeked value, the search outcome
// (found and 1-based position from the bottom, taken modulo 128), whether the
// stack is empty afterwards, and a status of ok, underflow (pop or peek on an
// empty stack) or overflow (push onto a full stack, value dropped). The block
// handles one request at a time: request ready is high only while it is idle.
// Push, and any request that underflows or overflows, goes straight to the
// response load; pop and peek first make one registered read of the entry
// memory; a search walks the single read port of the entry memory one entry
// per cycle from the bottom and stops at the first match, or after the last
// of the stored entries. A finished response sits in an output register, so
// the block returns to idle as soon as it is loaded. The entry memory needs
// no clearing after reset: only entries below the count ever reach a result
// or a compare.

module lifo_stack_with_search import lsws_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    lsws_req_if.sink          i_req,
    lsws_rsp_if.source        o_rsp
);

    t_cmd    w_cmd;     // controller commands
    t_status w_st;      // datapath status back to the controller

    // Sequence each request through accept, memory access and response load
    lsws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    // Hold the entries, the count, the search walk and the response register
    lsws_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_st            (w_st),
        .i_opcode        (i_req.opcode),
        .i_operand_value (i_req.operand_value),
        .i_rsp_ready     (o_rsp.ready),
        .o_rsp_valid     (o_rsp.valid),
        .o_result_value  (o_rsp.result_value),
        .o_found         (o_rsp.found),
        .o_position      (o_rsp.position),
        .o_is_empty      (o_rsp.is_empty),
        .o_status        (o_rsp.status)
    );

endmodule

`default_nettype wire

@@ rtl/lsws_checker.sv @@
// Port-level checker of the stack block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "lifo_stack_with_search_defines.svh"

module lsws_checker import lsws_pkg::*; (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_req_valid,
    input wire                       i_req_ready,
    input wire                       i_rsp_valid,
    input wire                       i_rsp_ready,
    input wire signed [DATA_W-1:0]   i_result_value,
    input wire                       i_found,
    input wire        [POS_W-1:0]    i_position,
    input wire                       i_is_empty,
    input wire        [STATUS_W-1:0] i_status
);

    // A stalled response beat holds
    `LSWS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_result_value) && $stable(i_status) && $stable(i_position))

    // One request in flight: ready drops after each request beat
    `LSWS_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // Underflow only on an empty stack, with nothing reported
    `LSWS_ASSERT_IMPLY(a_underflow_clean, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_UNDERFLOW), i_is_empty && (i_result_value == '0) && !i_found)

    // Overflow means the stack is full, so never empty
    `LSWS_ASSERT_IMPLY(a_overflow_full, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_OVERFLOW), !i_is_empty && !i_found)

endmodule

bind lifo_stack_with_search lsws_checker u_lsws_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_result_value (o_rsp.result_value),
    .i_found        (o_rsp.found),
    .i_position     (o_rsp.position),
    .i_is_empty     (o_rsp.is_empty),
    .i_status       (o_rsp.status)
);

`default_nettype wire

@@ tb/lifo_stack_with_search_checker.sv @@
// Scoreboard for the stack block: predicts every response beat and checks it field by field.
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_search_checker import lsws_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    lsws_req_if  i_req,
    lsws_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_hits,
    output int   o_underflows,
    output int   o_overflows
);

    typedef struct packed {
        logic signed [DATA_W-1:0]   value;
        logic                       found;
        logic        [POS_W-1:0]    position;
        logic                       is_empty;
        logic        [STATUS_W-1:0] status;
    } t_stack_reply;

    logic signed [DATA_W-1:0] shadow_words [STACK_DEPTH];
    int unsigned              shadow_count = 0;
    t_stack_reply             reply_q [$];
    int                       fail_total = 0;
    int                       checked_total = 0;
    int                       hit_total = 0;
    int                       underflow_total = 0;
    int                       overflow_total = 0;

    // Apply one request to the shadow stack and return the response it must give.
    function automatic t_stack_reply step_stack(input logic [OPCODE_W-1:0] op,
                                                input logic signed [DATA_W-1:0] val);
        t_stack_reply r;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (shadow_count >= STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    shadow_words[shadow_count] = val;
                    shadow_count++;
                end
            end
            OP_POP: begin
                if (shadow_count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    shadow_count--;
                    r.value = shadow_words[shadow_count];
                end
            end
            OP_PEEK: begin
                if (shadow_count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.value = shadow_words[shadow_count - 1];
                end
            end
            default: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_words[i] == val) begin
                        r.found    = 1'b1;
                        r.position = POS_W'(i + 1);
                        break;
                    end
                end
            end
        endcase
        r.is_empty = (shadow_count == 0);
        return r;
    endfunction

    task automatic compare_reply(input t_stack_reply exp, input t_stack_reply got);
        if (got.value !== exp.value) begin
            $error("result_value: expected %0d, got %0d", exp.value, got.value);
            fail_total++;
        end
        if (got.found !== exp.found) begin
            $error("found: expected %0d, got %0d", exp.found, got.found);
            fail_total++;
        end
        if (got.position !== exp.position) begin
            $error("position: expected %0d, got %0d", exp.position, got.position);
            fail_total++;
        end
        if (got.is_empty !== exp.is_empty) begin
            $error("is_empty: expected %0d, got %0d", exp.is_empty, got.is_empty);
            fail_total++;
        end
        if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stack_reply got;
        t_stack_reply exp;
        if (!i_rst_n) begin
            shadow_count = 0;
            reply_q.delete();
        end else begin
            // Retire the response first: it can never belong to a request taken at this edge.
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                got.value    = i_rsp.result_value;
                got.found    = i_rsp.found;
                got.position = i_rsp.position;
                got.is_empty = i_rsp.is_empty;
                got.status   = i_rsp.status;
                if (reply_q.size() == 0) begin
                    $error("response beat with no request outstanding");
                    fail_total++;
                end else begin
                    compare_reply(reply_q.pop_front(), got);
                    checked_total++;
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                exp = step_stack(i_req.opcode, i_req.operand_value);
                reply_q.push_back(exp);
                if (exp.found) hit_total++;
                if (exp.status == ST_UNDERFLOW) underflow_total++;
                if (exp.status == ST_OVERFLOW) overflow_total++;
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= reply_q.size();
        o_checked    <= checked_total;
        o_hits       <= hit_total;
        o_underflows <= underflow_total;
        o_overflows  <= overflow_total;
    end

endmodule

`default_nettype wire

@@ tb/tb_lifo_stack_with_search.sv @@
// Testbench top for the stack block: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_lifo_stack_with_search import lsws_pkg::*;;

    localparam int STACK_DEPTH      = 64;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_SEGMENTS  = 30;
    localparam int SEGMENT_BEATS    = 60;
    // Final segments run with both sides at full rate.
    localparam int QUIET_SEGMENTS   = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    // Idle time after the last drain, with a margin beyond a full-depth search.
    localparam int DRAIN_CYCLES     = 80;
    localparam int POOL_LIMIT       = 256;

    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] ALL_ONES = -32'sd1;

    // Opcode blend of a random segment: grow the stack, shrink it, or wander.
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_MIXED} t_op_mix;

    logic i_clk;
    logic i_rst_n;

    lsws_req_if req_ch ();
    lsws_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int checked;
    int hits;
    int underflows;
    int overflows;

    bit idle_on          = 1'b1;
    int long_hold_ticket = 0;
    int long_hold_served = 0;
    int hold_left        = 0;
    int cycle_cnt        = 0;
    int op_sent [4]      = '{default: 0};

    // Values already pushed, so that most searches have something to hit.
    logic signed [DATA_W-1:0] pushed_pool [$];

    lifo_stack_with_search #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    lifo_stack_with_search_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits),
        .o_underflows (underflows),
        .o_overflows  (overflows)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: abandon the run if the block stops answering.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Response side. A request for a long hold takes priority; otherwise drop ready
    // in short random bursts while idling is enabled, and hold it high when it is not.
    always @(posedge i_clk) begin
        if (long_hold_ticket != long_hold_served) begin
            long_hold_served = long_hold_ticket;
            hold_left = LONG_HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 5);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Offer one request beat and hold it until the block takes it. An optional gap
    // beforehand lowers valid; without a gap valid stays high straight into this beat.
    task automatic send_beat(input logic [OPCODE_W-1:0] op,
                             input logic signed [DATA_W-1:0] val);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= op;
        req_ch.operand_value <= val;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        op_sent[op]++;
        if (op == OP_PUSH) begin
            pushed_pool.push_back(val);
            if (pushed_pool.size() > POOL_LIMIT) void'(pushed_pool.pop_front());
        end
    endtask

    // Lower valid and wait until every outstanding response has been checked.
    task automatic hold_sender_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly full-range words, some extremes, and a narrow band that breeds duplicates.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5: begin
                case ($urandom_range(0, 4))
                    0: return MOST_POS;
                    1: return MOST_NEG;
                    2: return ALL_ONES;
                    3: return 32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_search_value();
        if (pushed_pool.size() != 0 && $urandom_range(0, 9) < 6)
            return pushed_pool[$urandom_range(0, pushed_pool.size() - 1)];
        return pick_value();
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_op(input t_op_mix mix);
        int roll;
        int push_cut;
        int pop_cut;
        int peek_cut;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                push_cut = 70; pop_cut = 80; peek_cut = 90;
            end
            MIX_DRAIN: begin
                push_cut = 15; pop_cut = 70; peek_cut = 82;
            end
            default: begin
                push_cut = 35; pop_cut = 60; peek_cut = 75;
            end
        endcase
        if (roll < push_cut) return OP_PUSH;
        if (roll < pop_cut) return OP_POP;
        if (roll < peek_cut) return OP_PEEK;
        return OP_SEARCH;
    endfunction

    task automatic random_beat(input t_op_mix mix);
        logic [OPCODE_W-1:0] op;
        op = pick_op(mix);
        send_beat(op, (op == OP_SEARCH) ? pick_search_value() : pick_value());
    endtask

    // Stall the response side for a long stretch while pushing past full depth, so the
    // block backs up into its request port and the last pushes overflow. Then search
    // for the bottom and top words of that run and peek the top.
    task automatic fill_under_long_hold();
        logic signed [DATA_W-1:0] word;
        logic signed [DATA_W-1:0] bottom_word;
        logic signed [DATA_W-1:0] top_word;
        long_hold_ticket <= long_hold_ticket + 1;
        bottom_word = '0;
        top_word    = '0;
        for (int n = 0; n < STACK_DEPTH + 2; n++) begin
            word = $urandom;
            send_beat(OP_PUSH, word);
            if (n == 0) bottom_word = word;
            if (n == STACK_DEPTH - 1) top_word = word;
        end
        send_beat(OP_SEARCH, top_word);
        send_beat(OP_SEARCH, bottom_word);
        send_beat(OP_PEEK, pick_value());
    endtask

    initial begin
        t_op_mix mix;

        req_ch.valid         <= 1'b0;
        req_ch.opcode        <= OP_PUSH;
        req_ch.operand_value <= '0;
        i_rst_n              <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty stack: pop and peek underflow, search misses.
        send_beat(OP_POP, MOST_POS);
        send_beat(OP_PEEK, MOST_NEG);
        send_beat(OP_SEARCH, 32'sd0);
        // Extremes, with a duplicate of the first word on top.
        send_beat(OP_PUSH, MOST_POS);
        send_beat(OP_PUSH, MOST_NEG);
        send_beat(OP_PUSH, 32'sd0);
        send_beat(OP_PUSH, ALL_ONES);
        send_beat(OP_PUSH, MOST_POS);
        // The first match from the bottom wins over the duplicate on top.
        send_beat(OP_SEARCH, MOST_POS);
        send_beat(OP_SEARCH, ALL_ONES);
        send_beat(OP_SEARCH, MOST_NEG);
        send_beat(OP_SEARCH, 32'sh5A5A_5A5A);
        send_beat(OP_PEEK, 32'sd0);
        send_beat(OP_POP, ALL_ONES);
        send_beat(OP_POP, 32'sd0);
        send_beat(OP_PEEK, MOST_POS);
        send_beat(OP_POP, 32'sd0);
        send_beat(OP_POP, 32'sd0);
        // Popping the only entry leaves the stack empty.
        send_beat(OP_POP, 32'sd0);
        send_beat(OP_POP, 32'sd0);
        send_beat(OP_SEARCH, 32'sd0);
        send_beat(OP_PUSH, 32'sh5555_5555);
        send_beat(OP_PUSH, 32'shAAAA_AAAA);
        send_beat(OP_POP, 32'sd0);
        send_beat(OP_POP, 32'sd0);

        hold_sender_until_drained();
        fill_under_long_hold();

        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            if (seg == RANDOM_SEGMENTS / 2) begin
                hold_sender_until_drained();
                fill_under_long_hold();
            end
            idle_on = (seg < RANDOM_SEGMENTS - QUIET_SEGMENTS) && ($urandom_range(0, 4) != 0);
            mix = t_op_mix'($urandom_range(0, 2));
            repeat (SEGMENT_BEATS) random_beat(mix);
        end

        hold_sender_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d push, %0d pop, %0d peek, %0d search.",
                 op_sent[OP_PUSH] + op_sent[OP_POP] + op_sent[OP_PEEK] + op_sent[OP_SEARCH],
                 op_sent[OP_PUSH], op_sent[OP_POP], op_sent[OP_PEEK], op_sent[OP_SEARCH]);
        $display("Checked %0d responses: %0d search hits, %0d underflows, %0d overflows.",
                 checked, hits, underflows, overflows);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
